// File: rtl/core/assert_macros.svh
// assertion helpers used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge out of reset
`define TC2_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// condition that holds at every clock edge out of reset
`define TC2_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("invariant check failed");

`endif

// File: rtl/core/tc2_pkg.sv
// ----------------------------------------------------------------------------
// tc2_pkg
// types, constants and helpers for the 2d transform compose core
// ----------------------------------------------------------------------------
package tc2_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN     = 24;
	localparam int CORDIC_N     = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam int SHW          = $clog2(ATAN_LEN);

	localparam int VW = 35;
	localparam int ZW = 34;

	localparam longint PERIOD    = longint'(360) << FRAC_BITS;
	localparam longint HALF      = longint'(180) << FRAC_BITS;
	localparam longint QUARTER   = longint'(90) << FRAC_BITS;
	localparam longint OFFSET    = ((longint'(1) << 31) + PERIOD - 1) / PERIOD * PERIOD;
	localparam longint VMAX      = OFFSET + (longint'(1) << 31);
	localparam int     RED_STEPS = $clog2(VMAX / PERIOD + 1);

	localparam longint DEG_TO_RAD = 18740330;
	localparam longint GAIN       = 652032874;

	// s1, reduction, fold, radians, cordic, products, sums, output
	localparam int LATENCY = RED_STEPS + CORDIC_N + 6;

	typedef struct packed {
		logic signed [31:0] parent_x;
		logic signed [31:0] parent_y;
		logic signed [31:0] parent_rotation;
		logic signed [31:0] parent_scale_x;
		logic signed [31:0] parent_scale_y;
		logic signed [31:0] local_x;
		logic signed [31:0] local_y;
		logic signed [31:0] local_rotation;
		logic signed [31:0] local_scale_x;
		logic signed [31:0] local_scale_y;
	} in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_rotation;
		logic signed [31:0] out_scale_x;
		logic signed [31:0] out_scale_y;
	} out_t;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] rot;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] osx;
		logic signed [31:0] osy;
	} side_t;

	typedef struct packed {
		logic [VW-1:0] v;
		side_t         side;
	} red_t;

	typedef struct packed {
		logic signed [ZW-1:0] x;
		logic signed [ZW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 flip;
		side_t                side;
	} cor_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] r;
		case (i)
			0:       r = 32'h3243F6A8;
			1:       r = 32'h1DAC6705;
			2:       r = 32'h0FADBAFC;
			3:       r = 32'h07F56EA6;
			4:       r = 32'h03FEAB76;
			5:       r = 32'h01FFD55B;
			6:       r = 32'h00FFFAAA;
			7:       r = 32'h007FFF55;
			8:       r = 32'h003FFFEA;
			9:       r = 32'h001FFFFD;
			10:      r = 32'h000FFFFF;
			11:      r = 32'h0007FFFF;
			12:      r = 32'h0003FFFF;
			13:      r = 32'h0001FFFF;
			14:      r = 32'h0000FFFF;
			15:      r = 32'h00007FFF;
			16:      r = 32'h00003FFF;
			17:      r = 32'h00001FFF;
			18:      r = 32'h00000FFF;
			19:      r = 32'h000007FF;
			20:      r = 32'h000003FF;
			21:      r = 32'h000001FF;
			22:      r = 32'h000000FF;
			23:      r = 32'h0000007F;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/tc2_red_cell.sv
// ----------------------------------------------------------------------------
// tc2_red_cell
// one restoring step of the angle reduction: subtract a multiple of the period
// ----------------------------------------------------------------------------
module tc2_red_cell import tc2_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cur_valid,
	input  red_t          cur,
	input  logic [VW-1:0] sub,
	output logic          nxt_valid,
	output red_t          nxt
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nxt_valid <= 1'b0;
		end else begin
			nxt_valid <= cur_valid;
		end
	end

	always_ff @(posedge clk) begin
		nxt.side <= cur.side;
		nxt.v    <= (cur.v >= sub) ? cur.v - sub : cur.v;
	end

endmodule

// File: rtl/core/tc2_cordic_cell.sv
// ----------------------------------------------------------------------------
// tc2_cordic_cell
// one rotation-mode cordic micro-rotation
// ----------------------------------------------------------------------------
module tc2_cordic_cell import tc2_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cur_valid,
	input  cor_t                 cur,
	input  logic [SHW-1:0]       shamt,
	input  logic signed [ZW-1:0] atan,
	output logic                 nxt_valid,
	output cor_t                 nxt
);

	logic signed [ZW-1:0] dx;
	logic signed [ZW-1:0] dy;

	assign dx = cur.y >>> shamt;
	assign dy = cur.x >>> shamt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nxt_valid <= 1'b0;
		end else begin
			nxt_valid <= cur_valid;
		end
	end

	always_ff @(posedge clk) begin
		nxt.flip <= cur.flip;
		nxt.side <= cur.side;
		if (!cur.z[ZW-1]) begin
			nxt.x <= cur.x - dx;
			nxt.y <= cur.y + dy;
			nxt.z <= cur.z - atan;
		end else begin
			nxt.x <= cur.x + dx;
			nxt.y <= cur.y - dy;
			nxt.z <= cur.z + atan;
		end
	end

endmodule

// File: rtl/core/transform_compose_2d_core.sv
// ----------------------------------------------------------------------------
// transform_compose_2d_core
// composes a parent 2d transform with a local one, fully pipelined
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  request   start / busy     req (in_t)
//  result    done strobe      res (out_t)
//
//  one request per cycle, busy stays low
//  data pass through the s1, angle reduction, fold, radians, cordic,
//  products, sums and output registers
//  reset clears the valid bits only, no clearing pass
//  results are shown for one cycle and cannot be stalled
module transform_compose_2d_core import tc2_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  req,
	output logic done,
	output out_t res
);

	logic               valid_s1;
	logic signed [31:0] px_s1, py_s1, rot_s1;
	logic signed [63:0] msx_s1, msy_s1, mosx_s1, mosy_s1;
	logic [VW-1:0]      v_s1;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		px_s1   <= req.parent_x;
		py_s1   <= req.parent_y;
		rot_s1  <= sat32(64'(req.parent_rotation) + 64'(req.local_rotation));
		msx_s1  <= req.local_x * req.parent_scale_x;
		msy_s1  <= req.local_y * req.parent_scale_y;
		mosx_s1 <= req.parent_scale_x * req.local_scale_x;
		mosy_s1 <= req.parent_scale_y * req.local_scale_y;
		v_s1    <= {{(VW-32){req.parent_rotation[31]}}, req.parent_rotation} + VW'(OFFSET);
	end

	red_t red_bus [RED_STEPS+1];
	logic red_vld [RED_STEPS+1];

	assign red_vld[0]          = valid_s1;
	assign red_bus[0].v        = v_s1;
	assign red_bus[0].side.px  = px_s1;
	assign red_bus[0].side.py  = py_s1;
	assign red_bus[0].side.rot = rot_s1;
	assign red_bus[0].side.sx  = sat32(msx_s1 >>> FRAC_BITS);
	assign red_bus[0].side.sy  = sat32(msy_s1 >>> FRAC_BITS);
	assign red_bus[0].side.osx = sat32(mosx_s1 >>> FRAC_BITS);
	assign red_bus[0].side.osy = sat32(mosy_s1 >>> FRAC_BITS);

	for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
		localparam logic [VW-1:0] SUB = VW'(PERIOD << (RED_STEPS - 1 - j));
		tc2_red_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cur_valid (red_vld[j]),
			.cur       (red_bus[j]),
			.sub       (SUB),
			.nxt_valid (red_vld[j+1]),
			.nxt       (red_bus[j+1])
		);
	end

	// fold into [-90, 90] degrees
	logic signed [VW-1:0] a_red, a_wrap, a_fold;
	logic                 flip_fold;

	always_comb begin
		a_red     = $signed(red_bus[RED_STEPS].v);
		a_wrap    = (a_red > VW'(HALF)) ? a_red - VW'(PERIOD) : a_red;
		flip_fold = 1'b0;
		a_fold    = a_wrap;
		if (a_wrap > VW'(QUARTER)) begin
			a_fold    = a_wrap - VW'(HALF);
			flip_fold = 1'b1;
		end else if (a_wrap < -$signed(VW'(QUARTER))) begin
			a_fold    = a_wrap + VW'(HALF);
			flip_fold = 1'b1;
		end
	end

	logic                 valid_s2;
	logic signed [VW-1:0] a_s2;
	logic                 flip_s2;
	side_t                side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= red_vld[RED_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		a_s2    <= a_fold;
		flip_s2 <= flip_fold;
		side_s2 <= red_bus[RED_STEPS].side;
	end

	logic signed [63:0] rad_prod;
	assign rad_prod = 64'(a_s2) * 64'(DEG_TO_RAD);

	cor_t cor_bus [CORDIC_N+1];
	logic cor_vld [CORDIC_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cor_vld[0] <= 1'b0;
		end else begin
			cor_vld[0] <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		cor_bus[0].x    <= ZW'(GAIN);
		cor_bus[0].y    <= '0;
		cor_bus[0].z    <= ZW'(rad_prod >>> FRAC_BITS);
		cor_bus[0].flip <= flip_s2;
		cor_bus[0].side <= side_s2;
	end

	for (genvar j = 0; j < CORDIC_N; j++) begin : g_cor
		tc2_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cur_valid (cor_vld[j]),
			.cur       (cor_bus[j]),
			.shamt     (SHW'(j)),
			.atan      ($signed({{(ZW-32){1'b0}}, atan_q30(j)})),
			.nxt_valid (cor_vld[j+1]),
			.nxt       (cor_bus[j+1])
		);
	end

	cor_t               cend;
	logic               valid_s4;
	logic signed [65:0] pcx_s4, psy_s4, psx_s4, pcy_s4;
	logic               flip_s4;
	side_t              side_s4;

	assign cend = cor_bus[CORDIC_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= cor_vld[CORDIC_N];
		end
	end

	always_ff @(posedge clk) begin
		pcx_s4  <= cend.x * cend.side.sx;
		psy_s4  <= cend.y * cend.side.sy;
		psx_s4  <= cend.y * cend.side.sx;
		pcy_s4  <= cend.x * cend.side.sy;
		flip_s4 <= cend.flip;
		side_s4 <= cend.side;
	end

	logic               valid_s5;
	logic signed [66:0] dx_s5, dy_s5;
	side_t              side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		side_s5 <= side_s4;
		if (flip_s4) begin
			dx_s5 <= 67'(psy_s4) - 67'(pcx_s4);
			dy_s5 <= -67'(psx_s4) - 67'(pcy_s4);
		end else begin
			dx_s5 <= 67'(pcx_s4) - 67'(psy_s4);
			dy_s5 <= 67'(psx_s4) + 67'(pcy_s4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		res.out_x        <= sat32(64'(side_s5.px) + 64'(dx_s5 >>> 30));
		res.out_y        <= sat32(64'(side_s5.py) + 64'(dy_s5 >>> 30));
		res.out_rotation <= side_s5.rot;
		res.out_scale_x  <= side_s5.osx;
		res.out_scale_y  <= side_s5.osy;
	end

endmodule

// File: rtl/core/tc2_chk.sv
// ----------------------------------------------------------------------------
// tc2_chk
// port-level checks for the 2d transform compose core
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tc2_chk import tc2_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input in_t  req,
	input logic done,
	input out_t res
);

	`TC2_ASSERT_ALWAYS(a_never_busy, !busy)
	`TC2_ASSERT_IMP(a_done_has_request, done, $past(start, LATENCY))
	`TC2_ASSERT_IMP(a_rotation_sum, done, res.out_rotation == sat32(64'($past(req.parent_rotation, LATENCY)) + 64'($past(req.local_rotation, LATENCY))))

endmodule

bind transform_compose_2d_core tc2_chk u_tc2_chk (.*);
